/* design/container_deframer_ring_writer_defines.svh */
// ----------------------------------------------------------------------------
// Container deframer ring writer: assertion macros
// Shared concurrent assertion shorthands for the deframer design files.
// ----------------------------------------------------------------------------
`ifndef CONTAINER_DEFRAMER_RING_WRITER_DEFINES_SVH
`define CONTAINER_DEFRAMER_RING_WRITER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define CDRW_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cdrw: same-cycle property violated");

// Next-cycle implication, disabled while reset is high.
`define CDRW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cdrw: next-cycle property violated");

`endif

/* design/cdrw_pkg.sv */
// ----------------------------------------------------------------------------
// Container deframer ring writer: package
// Types, codes and constants shared by the deframer modules and interfaces.
// ----------------------------------------------------------------------------
package cdrw_pkg;

   localparam int ADDR_W = 32;
   localparam int DATA_W = 32;
   localparam int BYTE_W = 8;

   localparam int PACKET_BYTES      = 188;
   localparam int META_RECORD_BYTES = 16;
   localparam int META_PTR_OFFSET   = 12;
   localparam int HEADER_BYTES      = 8;

   localparam logic [BYTE_W-1:0] SYNC_BYTE     = 8'h5A;
   localparam logic [BYTE_W-1:0] TYPE_ERR_MASK = 8'hC0;
   localparam logic [BYTE_W-1:0] PACKET_LEN8   = BYTE_W'(PACKET_BYTES);
   localparam logic [BYTE_W-1:0] HEADER_LEN8   = BYTE_W'(HEADER_BYTES);

   // Result queue; depth must be a power of two.
   localparam int MAX_RESULTS = 2;
   localparam int QUEUE_DEPTH = 8;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);
   localparam int FILL_W      = QUEUE_CW + 1;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_SYNC1,
      PH_SYNC2,
      PH_SYNC3,
      PH_TYPE,
      PH_LEN_HI,
      PH_LEN_LO,
      PH_COUNTER,
      PH_PAYLOAD
   } phase_type;

   typedef enum logic [1:0] {
      LAYER_INVALID,
      LAYER_BASEBAND,
      LAYER_ALP,
      LAYER_CONTAINER
   } layer_type;

   typedef enum logic [2:0] {
      CSR_CHANNEL_ENABLE,
      CSR_CHANNEL_LAYER,
      CSR_PLP_FILTER_ENABLE,
      CSR_PLP_FILTER_ID,
      CSR_DATA_RING_START,
      CSR_DATA_RING_END,
      CSR_META_RING_START,
      CSR_META_RING_END
   } csr_index_type;

   typedef struct packed {
      logic                enable;
      csr_index_type       index;
      logic [DATA_W-1:0]   data;
   } csr_write_type;

   typedef struct packed {
      logic [ADDR_W-1:0] write_address;
      logic [DATA_W-1:0] write_data;
      logic              write_is_word;
      logic              meta_event;
      logic              last_of_run;
   } result_type;

   // Up to two results per byte; the second slot is used only with the first.
   typedef struct packed {
      logic       valid0;
      logic       valid1;
      result_type res0;
      result_type res1;
   } push_type;

endpackage

/* design/cdrw_req_if.sv */
// ----------------------------------------------------------------------------
// Container deframer ring writer: stream byte channel
// Valid/ready channel carrying one stream byte per beat.
// ----------------------------------------------------------------------------
interface cdrw_req_if;

   logic                          valid;
   logic                          ready;
   logic [cdrw_pkg::BYTE_W-1:0]   stream_byte;

   modport source (output valid, output stream_byte, input ready);
   modport sink (input valid, input stream_byte, output ready);

endinterface

/* design/cdrw_rsp_if.sv */
// ----------------------------------------------------------------------------
// Container deframer ring writer: memory write channel
// Valid/ready channel carrying one memory write per beat.
// ----------------------------------------------------------------------------
interface cdrw_rsp_if;

   logic                          valid;
   logic                          ready;
   logic [cdrw_pkg::ADDR_W-1:0]   write_address;
   logic [cdrw_pkg::DATA_W-1:0]   write_data;
   logic                          write_is_word;
   logic                          meta_event;
   logic                          last_of_run;

   modport source (
      output valid, output write_address, output write_data,
      output write_is_word, output meta_event, output last_of_run,
      input ready
   );
   modport sink (
      input valid, input write_address, input write_data,
      input write_is_word, input meta_event, input last_of_run,
      output ready
   );

endinterface

/* design/cdrw_core.sv */
// ----------------------------------------------------------------------------
// Container deframer ring writer: parser and ring pointer core
// Parses one byte per cycle, holds the control registers and ring pointers,
// and produces the memory writes caused by each byte.
// ----------------------------------------------------------------------------
module cdrw_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [cdrw_pkg::BYTE_W-1:0]   in_byte,
   input  cdrw_pkg::csr_write_type       csr,
   output cdrw_pkg::push_type            push
);

   // Control registers.
   logic                          enable_ff, enable_in;
   cdrw_pkg::layer_type           layer_ff, layer_in;
   logic                          filt_en_ff, filt_en_in;
   logic [5:0]                    filt_id_ff, filt_id_in;
   logic [cdrw_pkg::ADDR_W-1:0]   dstart_ff, dstart_in;
   logic [cdrw_pkg::ADDR_W-1:0]   dend_ff, dend_in;
   logic [cdrw_pkg::ADDR_W-1:0]   mstart_ff, mstart_in;
   logic [cdrw_pkg::ADDR_W-1:0]   mend_ff, mend_in;

   // Parser state and pointers.
   cdrw_pkg::phase_type           phase_ff, phase_in;
   logic [5:0]                    plp_ff, plp_in;
   logic [15:0]                   len_ff, len_in;
   logic [15:0]                   count_ff, count_in;
   logic [31:0]                   header_ff, header_in;
   logic [7:0]                    pad_ff, pad_in;
   logic [7:0]                    pos_ff, pos_in;
   logic [cdrw_pkg::ADDR_W-1:0]   dptr_ff, dptr_in;
   logic [cdrw_pkg::ADDR_W-1:0]   mptr_ff, mptr_in;

   cdrw_pkg::phase_type           phase_eff;
   logic [7:0]                    pad_eff;
   logic                          meta_now;
   logic                          active;
   logic                          is_sync;
   logic [cdrw_pkg::ADDR_W-1:0]   dnext;
   logic [cdrw_pkg::ADDR_W-1:0]   mnext;

   assign is_sync = (in_byte == cdrw_pkg::SYNC_BYTE);
   assign dnext   = dptr_ff + 32'd1;
   assign mnext   = mptr_ff + 32'(cdrw_pkg::META_RECORD_BYTES);

   always_comb begin
      enable_in  = enable_ff;
      layer_in   = layer_ff;
      filt_en_in = filt_en_ff;
      filt_id_in = filt_id_ff;
      dstart_in  = dstart_ff;
      dend_in    = dend_ff;
      mstart_in  = mstart_ff;
      mend_in    = mend_ff;
      phase_in   = phase_ff;
      plp_in     = plp_ff;
      len_in     = len_ff;
      count_in   = count_ff;
      header_in  = header_ff;
      pad_in     = pad_ff;
      pos_in     = pos_ff;
      dptr_in    = dptr_ff;
      mptr_in    = mptr_ff;
      phase_eff  = phase_ff;
      pad_eff    = pad_ff;
      meta_now   = 1'b0;
      active     = 1'b0;
      push       = '0;

      if (in_valid) begin
         // The byte after the last payload byte is already the first pad byte.
         // pos_ff tracks the container length modulo the packet size.
         if (phase_ff == cdrw_pkg::PH_PAYLOAD && count_ff == len_ff) begin
            phase_eff = cdrw_pkg::PH_IDLE;
            pad_eff   = (pos_ff == 8'd0) ? 8'd0 : cdrw_pkg::PACKET_LEN8 - pos_ff;
         end
         phase_in = phase_eff;
         pad_in   = pad_eff;

         unique case (phase_eff)
            cdrw_pkg::PH_IDLE: begin
               if (pad_eff != 8'd0) begin
                  pad_in = pad_eff - 8'd1;
               end else if (is_sync) begin
                  phase_in = cdrw_pkg::PH_SYNC1;
               end
            end
            cdrw_pkg::PH_SYNC1: begin
               phase_in = is_sync ? cdrw_pkg::PH_SYNC2 : cdrw_pkg::PH_IDLE;
            end
            cdrw_pkg::PH_SYNC2: begin
               phase_in = is_sync ? cdrw_pkg::PH_SYNC3 : cdrw_pkg::PH_IDLE;
            end
            cdrw_pkg::PH_SYNC3: begin
               phase_in = is_sync ? cdrw_pkg::PH_TYPE : cdrw_pkg::PH_IDLE;
            end
            cdrw_pkg::PH_TYPE: begin
               if ((in_byte & cdrw_pkg::TYPE_ERR_MASK) == cdrw_pkg::TYPE_ERR_MASK) begin
                  phase_in = cdrw_pkg::PH_IDLE;
               end else begin
                  plp_in    = in_byte[5:0];
                  header_in = {in_byte, 24'h000000};
                  phase_in  = cdrw_pkg::PH_LEN_HI;
               end
            end
            cdrw_pkg::PH_LEN_HI: begin
               len_in    = {in_byte, 8'h00};
               header_in = header_ff | {8'h00, in_byte, 16'h0000};
               phase_in  = cdrw_pkg::PH_LEN_LO;
            end
            cdrw_pkg::PH_LEN_LO: begin
               len_in    = len_ff | {8'h00, in_byte};
               header_in = header_ff | {16'h0000, in_byte, 8'h00};
               phase_in  = cdrw_pkg::PH_COUNTER;
            end
            cdrw_pkg::PH_COUNTER: begin
               if (len_ff == 16'd0) begin
                  phase_in = cdrw_pkg::PH_IDLE;
               end else begin
                  count_in  = 16'd0;
                  pos_in    = cdrw_pkg::HEADER_LEN8;
                  header_in = header_ff | {24'h000000, in_byte};
                  phase_in  = cdrw_pkg::PH_PAYLOAD;
                  meta_now  = 1'b1;
               end
            end
            cdrw_pkg::PH_PAYLOAD: begin
               count_in = count_ff + 16'd1;
               pos_in   = (pos_ff == cdrw_pkg::PACKET_LEN8 - 8'd1) ? 8'd0 : pos_ff + 8'd1;
            end
            default: begin
               phase_in = cdrw_pkg::PH_IDLE;
            end
         endcase

         active = enable_ff && (layer_ff == cdrw_pkg::LAYER_BASEBAND)
                  && !(filt_en_ff && filt_id_ff != plp_in)
                  && (phase_in == cdrw_pkg::PH_PAYLOAD);

         if (active) begin
            if (meta_now) begin
               // Meta record: header word first, then the data pointer.
               push.valid0 = 1'b1;
               push.valid1 = 1'b1;
               push.res0   = '{write_address: mptr_ff, write_data: header_in,
                               write_is_word: 1'b1, meta_event: 1'b0,
                               last_of_run: 1'b0};
               push.res1   = '{write_address: mptr_ff + 32'(cdrw_pkg::META_PTR_OFFSET),
                               write_data: dptr_ff, write_is_word: 1'b1,
                               meta_event: 1'b1, last_of_run: 1'b1};
               mptr_in     = (mnext >= mend_ff) ? mstart_ff : mnext;
            end else begin
               push.valid0 = 1'b1;
               push.res0   = '{write_address: dptr_ff, write_data: {24'h000000, in_byte},
                               write_is_word: 1'b0, meta_event: 1'b0,
                               last_of_run: 1'b1};
               dptr_in     = (dnext == dend_ff) ? dstart_ff : dnext;
            end
         end
      end

      if (csr.enable) begin
         unique case (csr.index)
            cdrw_pkg::CSR_CHANNEL_ENABLE: begin
               enable_in = csr.data[0];
               if (csr.data[0]) begin
                  dptr_in = dstart_ff;
                  mptr_in = mstart_ff;
               end
            end
            cdrw_pkg::CSR_CHANNEL_LAYER:     layer_in   = cdrw_pkg::layer_type'(csr.data[1:0]);
            cdrw_pkg::CSR_PLP_FILTER_ENABLE: filt_en_in = csr.data[0];
            cdrw_pkg::CSR_PLP_FILTER_ID:     filt_id_in = csr.data[5:0];
            cdrw_pkg::CSR_DATA_RING_START:   dstart_in  = csr.data;
            cdrw_pkg::CSR_DATA_RING_END:     dend_in    = csr.data;
            cdrw_pkg::CSR_META_RING_START:   mstart_in  = csr.data;
            cdrw_pkg::CSR_META_RING_END:     mend_in    = csr.data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff  <= 1'b0;
         layer_ff   <= cdrw_pkg::LAYER_INVALID;
         filt_en_ff <= 1'b0;
         filt_id_ff <= '0;
         dstart_ff  <= '0;
         dend_ff    <= '0;
         mstart_ff  <= '0;
         mend_ff    <= '0;
         phase_ff   <= cdrw_pkg::PH_IDLE;
         plp_ff     <= '0;
         len_ff     <= '0;
         count_ff   <= '0;
         header_ff  <= '0;
         pad_ff     <= '0;
         pos_ff     <= '0;
         dptr_ff    <= '0;
         mptr_ff    <= '0;
      end else begin
         enable_ff  <= enable_in;
         layer_ff   <= layer_in;
         filt_en_ff <= filt_en_in;
         filt_id_ff <= filt_id_in;
         dstart_ff  <= dstart_in;
         dend_ff    <= dend_in;
         mstart_ff  <= mstart_in;
         mend_ff    <= mend_in;
         phase_ff   <= phase_in;
         plp_ff     <= plp_in;
         len_ff     <= len_in;
         count_ff   <= count_in;
         header_ff  <= header_in;
         pad_ff     <= pad_in;
         pos_ff     <= pos_in;
         dptr_ff    <= dptr_in;
         mptr_ff    <= mptr_in;
      end
   end

endmodule

/* design/cdrw_rsp_queue.sv */
// ----------------------------------------------------------------------------
// Container deframer ring writer: result queue
// Small register queue taking up to two writes per cycle and giving one.
// ----------------------------------------------------------------------------
module cdrw_rsp_queue (
   input  logic                              clock,
   input  logic                              reset,
   input  cdrw_pkg::push_type                push,
   input  logic                              pop,
   output cdrw_pkg::result_type              head,
   output logic [cdrw_pkg::QUEUE_CW-1:0]     count
);

   cdrw_pkg::result_type                 entry_ff [cdrw_pkg::QUEUE_DEPTH];
   logic [cdrw_pkg::QUEUE_AW-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [cdrw_pkg::QUEUE_AW-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [cdrw_pkg::QUEUE_CW-1:0]        count_ff, count_in;
   logic [cdrw_pkg::QUEUE_AW-1:0]        wr_ptr_plus1;

   assign wr_ptr_plus1 = wr_ptr_ff + cdrw_pkg::QUEUE_AW'(1);
   assign head         = entry_ff[rd_ptr_ff];
   assign count        = count_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + cdrw_pkg::QUEUE_AW'(push.valid0)
                            + cdrw_pkg::QUEUE_AW'(push.valid1);
      rd_ptr_in = rd_ptr_ff + cdrw_pkg::QUEUE_AW'(pop);
      count_in  = count_ff + cdrw_pkg::QUEUE_CW'(push.valid0)
                           + cdrw_pkg::QUEUE_CW'(push.valid1)
                           - cdrw_pkg::QUEUE_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid0) begin
         entry_ff[wr_ptr_ff] <= push.res0;
      end
      if (push.valid1) begin
         entry_ff[wr_ptr_plus1] <= push.res1;
      end
   end

endmodule

/* design/container_deframer_ring_writer.sv */
// ----------------------------------------------------------------------------
// Container deframer ring writer: top level
// Finds containers in a byte stream and writes meta records and payload
// bytes of one baseband channel into two memory rings.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one stream byte per beat; rsp_chan carries one memory
//   write per beat (address, data, word/byte flag, meta event, last flag).
//   The csr_ port writes one control register per cycle, with no read-back;
//   write it only while no byte is in flight.
// Timing:
//   An accepted byte is held in the input register while the parser works
//   on it; its writes are then registered into the result queue, from
//   which the first resulting beat is offered.
//   One byte is accepted per cycle while req_chan.ready is high. A counter
//   byte yields two beats and a payload byte one, and the output side gives
//   one beat per cycle, so a container's meta record adds one beat beyond
//   its bytes; the eight entry result queue absorbs it.
// Stalls and reset:
//   When rsp_chan.ready is low the queue fills and req_chan.ready drops
//   once fewer than two free entries remain for each byte in flight.
//   Reset clears the control registers and ring pointers to zero, the parser
//   to idle and empties the queue; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "container_deframer_ring_writer_defines.svh"

module container_deframer_ring_writer (
   input  logic                          clock,
   input  logic                          reset,
   cdrw_req_if.sink                      req_chan,
   cdrw_rsp_if.source                    rsp_chan,
   input  logic                          csr_write_enable,
   input  cdrw_pkg::csr_index_type       csr_index,
   input  logic [cdrw_pkg::DATA_W-1:0]   csr_write_data
);

   logic                                 in_valid_ff, in_valid_in;
   logic [cdrw_pkg::BYTE_W-1:0]          in_byte_ff;
   logic                                 req_accept;
   logic [cdrw_pkg::FILL_W-1:0]          fill_bound;
   logic [cdrw_pkg::QUEUE_CW-1:0]        q_count;
   logic                                 pop;
   cdrw_pkg::csr_write_type              csr;
   cdrw_pkg::push_type                   push;
   cdrw_pkg::result_type                 head;

   // Worst case the byte in the input register and the new one both bring
   // a meta record.
   assign fill_bound = cdrw_pkg::FILL_W'(q_count)
                     + (in_valid_ff ? cdrw_pkg::FILL_W'(2 * cdrw_pkg::MAX_RESULTS)
                                    : cdrw_pkg::FILL_W'(cdrw_pkg::MAX_RESULTS));
   assign req_chan.ready = (fill_bound <= cdrw_pkg::FILL_W'(cdrw_pkg::QUEUE_DEPTH));
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign in_valid_in    = req_accept;

   assign csr = '{enable: csr_write_enable, index: csr_index, data: csr_write_data};

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff <= req_chan.stream_byte;
      end
   end

   cdrw_core u_core (
      .clock    (clock),
      .reset    (reset),
      .in_valid (in_valid_ff),
      .in_byte  (in_byte_ff),
      .csr      (csr),
      .push     (push)
   );

   cdrw_rsp_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .count (q_count)
   );

   assign rsp_chan.valid         = (q_count != '0);
   assign pop                    = rsp_chan.valid && rsp_chan.ready;
   assign rsp_chan.write_address = head.write_address;
   assign rsp_chan.write_data    = head.write_data;
   assign rsp_chan.write_is_word = head.write_is_word;
   assign rsp_chan.meta_event    = head.meta_event;
   assign rsp_chan.last_of_run   = head.last_of_run;

   // A byte being parsed always finds room for both of its possible writes.
   `CDRW_ASSERT_IMPL(a_queue_room, clock, reset, in_valid_ff,
      q_count <= cdrw_pkg::QUEUE_CW'(cdrw_pkg::QUEUE_DEPTH - cdrw_pkg::MAX_RESULTS))
   // An accepted beat reaches the parser on the next cycle.
   `CDRW_ASSERT_NEXT(a_accept_to_parse, clock, reset, req_accept, in_valid_ff)
   // The meta event closes its record with a word write.
   `CDRW_ASSERT_IMPL(a_meta_event_shape, clock, reset,
      rsp_chan.valid && rsp_chan.meta_event,
      rsp_chan.write_is_word && rsp_chan.last_of_run)

endmodule
